>>> hw/rtl/llic_pkg.sv
// ----------------------------------------------------------------------------
// llic_pkg: shared widths and types for the line intersection core
// Coordinate width and the derived widths of the exact intermediate terms.
// ----------------------------------------------------------------------------
package llic_pkg;

    localparam int CW = 32;
    localparam int EW = CW + 1;
    localparam int PW = 2 * CW + 1;
    localparam int HW = PW - CW;
    localparam int MW = HW + EW;
    localparam int DW = 2 * EW + 1;
    localparam int NW = 3 * CW + 3;

    typedef struct packed {
        logic signed [NW-1:0] num_x;
        logic signed [NW-1:0] num_y;
        logic signed [DW-1:0] den;
    } item_t;

    typedef struct packed {
        logic par;
        logic sat_x;
        logic sat_y;
        logic neg_x;
        logic neg_y;
    } flag_t;

endpackage

>>> hw/rtl/line_line_intersection_core.sv
// Throughput: one line pair per cycle unless m_ready stalls; set by the fully
//   pipelined multipliers and the divider, one quotient bit per stage.
// Reset: synchronous active-low aresetn clears all valid flags and the queue;
//   data registers are not reset.
// ----------------------------------------------------------------------------
// line_line_intersection_core: intersection of two lines in signed Q16.16
// Front computes exact determinant terms, back divides and saturates.
// ----------------------------------------------------------------------------
module line_line_intersection_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [llic_pkg::CW-1:0] s_first_start_x,
    input  logic signed [llic_pkg::CW-1:0] s_first_start_y,
    input  logic signed [llic_pkg::CW-1:0] s_first_end_x,
    input  logic signed [llic_pkg::CW-1:0] s_first_end_y,
    input  logic signed [llic_pkg::CW-1:0] s_second_start_x,
    input  logic signed [llic_pkg::CW-1:0] s_second_start_y,
    input  logic signed [llic_pkg::CW-1:0] s_second_end_x,
    input  logic signed [llic_pkg::CW-1:0] s_second_end_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [llic_pkg::CW-1:0] m_cross_x,
    output logic signed [llic_pkg::CW-1:0] m_cross_y,
    output logic                           m_parallel,
    output logic                           m_overflow
);

    logic            f_valid, f_ready, b_valid, b_ready;
    llic_pkg::item_t f_data, b_data;

    llic_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_start_x  (s_first_start_x),
        .s_first_start_y  (s_first_start_y),
        .s_first_end_x    (s_first_end_x),
        .s_first_end_y    (s_first_end_y),
        .s_second_start_x (s_second_start_x),
        .s_second_start_y (s_second_start_y),
        .s_second_end_x   (s_second_end_x),
        .s_second_end_y   (s_second_end_y),
        .q_valid          (f_valid),
        .q_ready          (f_ready),
        .q_data           (f_data)
    );

    llic_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    llic_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (b_valid),
        .q_ready    (b_ready),
        .q_data     (b_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cross_x  (m_cross_x),
        .m_cross_y  (m_cross_y),
        .m_parallel (m_parallel),
        .m_overflow (m_overflow)
    );

endmodule

>>> hw/rtl/llic_front.sv
// ----------------------------------------------------------------------------
// llic_front: cross terms, denominator and numerators
// Five-stage pipeline producing exact numerators and the common denominator.
// ----------------------------------------------------------------------------
module llic_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [llic_pkg::CW-1:0]   s_first_start_x,
    input  logic signed [llic_pkg::CW-1:0]   s_first_start_y,
    input  logic signed [llic_pkg::CW-1:0]   s_first_end_x,
    input  logic signed [llic_pkg::CW-1:0]   s_first_end_y,
    input  logic signed [llic_pkg::CW-1:0]   s_second_start_x,
    input  logic signed [llic_pkg::CW-1:0]   s_second_start_y,
    input  logic signed [llic_pkg::CW-1:0]   s_second_end_x,
    input  logic signed [llic_pkg::CW-1:0]   s_second_end_y,
    output logic                             q_valid,
    input  logic                             q_ready,
    output llic_pkg::item_t                  q_data
);

    localparam int CW = llic_pkg::CW;
    localparam int EW = llic_pkg::EW;
    localparam int PW = llic_pkg::PW;
    localparam int MW = llic_pkg::MW;
    localparam int DW = llic_pkg::DW;
    localparam int NW = llic_pkg::NW;

    logic [4:0] valid_reg;
    logic       en;

    logic signed [EW-1:0]   e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [2*CW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [EW-1:0]   e1x2_reg, e1y2_reg, e2x2_reg, e2y2_reg;
    logic signed [PW-1:0]   t1_reg, t2_reg;
    logic signed [2*EW-1:0] dp0_reg, dp1_reg;
    logic signed [DW-1:0]   den3_reg, den4_reg, den5_reg;
    logic signed [MW-1:0]   hx1_reg, lx1_reg, hx2_reg, lx2_reg;
    logic signed [MW-1:0]   hy1_reg, ly1_reg, hy2_reg, ly2_reg;
    logic signed [NW-1:0]   mx1_reg, mx2_reg, my1_reg, my2_reg;
    logic signed [NW-1:0]   nx_reg, ny_reg;

    assign en      = !valid_reg[4] || q_ready;
    assign s_ready = en;
    assign q_valid = valid_reg[4];
    assign q_data  = '{num_x: nx_reg, num_y: ny_reg, den: den5_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1x_reg  <= EW'(s_first_start_x) - EW'(s_first_end_x);
            e1y_reg  <= EW'(s_first_start_y) - EW'(s_first_end_y);
            e2x_reg  <= EW'(s_second_start_x) - EW'(s_second_end_x);
            e2y_reg  <= EW'(s_second_start_y) - EW'(s_second_end_y);
            pa_reg   <= s_first_start_x * s_first_end_y;
            pb_reg   <= s_first_start_y * s_first_end_x;
            pc_reg   <= s_second_start_x * s_second_end_y;
            pd_reg   <= s_second_start_y * s_second_end_x;

            t1_reg   <= PW'(pa_reg) - PW'(pb_reg);
            t2_reg   <= PW'(pc_reg) - PW'(pd_reg);
            dp0_reg  <= e1x_reg * e2y_reg;
            dp1_reg  <= e1y_reg * e2x_reg;
            e1x2_reg <= e1x_reg;
            e1y2_reg <= e1y_reg;
            e2x2_reg <= e2x_reg;
            e2y2_reg <= e2y_reg;

            den3_reg <= DW'(dp0_reg) - DW'(dp1_reg);
            hx1_reg  <= $signed(t1_reg[PW-1:CW]) * e2x2_reg;
            lx1_reg  <= $signed({1'b0, t1_reg[CW-1:0]}) * e2x2_reg;
            hx2_reg  <= $signed(t2_reg[PW-1:CW]) * e1x2_reg;
            lx2_reg  <= $signed({1'b0, t2_reg[CW-1:0]}) * e1x2_reg;
            hy1_reg  <= $signed(t1_reg[PW-1:CW]) * e2y2_reg;
            ly1_reg  <= $signed({1'b0, t1_reg[CW-1:0]}) * e2y2_reg;
            hy2_reg  <= $signed(t2_reg[PW-1:CW]) * e1y2_reg;
            ly2_reg  <= $signed({1'b0, t2_reg[CW-1:0]}) * e1y2_reg;

            den4_reg <= den3_reg;
            mx1_reg  <= (NW'(hx1_reg) <<< CW) + NW'(lx1_reg);
            mx2_reg  <= (NW'(hx2_reg) <<< CW) + NW'(lx2_reg);
            my1_reg  <= (NW'(hy1_reg) <<< CW) + NW'(ly1_reg);
            my2_reg  <= (NW'(hy2_reg) <<< CW) + NW'(ly2_reg);

            den5_reg <= den4_reg;
            nx_reg   <= mx1_reg - mx2_reg;
            ny_reg   <= my1_reg - my2_reg;
        end
    end

endmodule

>>> hw/rtl/llic_fifo.sv
// ----------------------------------------------------------------------------
// llic_fifo: short queue between front and back
// Four-entry queue of numerator and denominator beats.
// ----------------------------------------------------------------------------
module llic_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  llic_pkg::item_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output llic_pkg::item_t out_data
);

    llic_pkg::item_t mem [4];
    logic [1:0]      wr_reg, rd_reg;
    logic [2:0]      count_reg;
    logic            push, pop;

    assign in_ready  = count_reg != 3'd4;
    assign out_valid = count_reg != 3'd0;
    assign out_data  = mem[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4) else $error("queue count out of range");
    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 3'd1)
        else $error("queue count missed a push");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_reg - rd_reg == count_reg[1:0]) else $error("queue pointers disagree");
`endif

endmodule

>>> hw/rtl/llic_back.sv
// ----------------------------------------------------------------------------
// llic_back: signed quotients with saturation
// Magnitudes, range precheck, one quotient bit per stage, output register.
// ----------------------------------------------------------------------------
module llic_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  llic_pkg::item_t                q_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [llic_pkg::CW-1:0] m_cross_x,
    output logic signed [llic_pkg::CW-1:0] m_cross_y,
    output logic                           m_parallel,
    output logic                           m_overflow
);

    localparam int CW = llic_pkg::CW;
    localparam int DW = llic_pkg::DW;
    localparam int NW = llic_pkg::NW;

    logic                en;
    logic [CW+1:0]       valid_reg;
    logic                m_valid_reg;

    logic [NW-1:0]       ax_reg, ay_reg;
    logic [DW-1:0]       ad_reg;
    llic_pkg::flag_t     fl_reg;

    logic [NW-1:0]       rx_reg [CW+1];
    logic [NW-1:0]       ry_reg [CW+1];
    logic [CW-1:0]       qx_reg [CW+1];
    logic [CW-1:0]       qy_reg [CW+1];
    logic [DW-1:0]       dd_reg [CW+1];
    llic_pkg::flag_t     fd_reg [CW+1];

    logic signed [CW-1:0] cx_reg, cy_reg;
    logic                 par_reg, ovf_reg;
    logic signed [CW-1:0] cx_next, cy_next;
    logic                 sx_next, sy_next;
    llic_pkg::flag_t      fe;

    assign en         = !m_valid_reg || m_ready;
    assign q_ready    = en;
    assign m_valid    = m_valid_reg;
    assign m_cross_x  = cx_reg;
    assign m_cross_y  = cy_reg;
    assign m_parallel = par_reg;
    assign m_overflow = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg   <= {valid_reg[CW:0], q_valid};
            m_valid_reg <= valid_reg[CW+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg       <= q_data.num_x[NW-1] ? NW'(-q_data.num_x) : NW'(q_data.num_x);
            ay_reg       <= q_data.num_y[NW-1] ? NW'(-q_data.num_y) : NW'(q_data.num_y);
            ad_reg       <= q_data.den[DW-1] ? DW'(-q_data.den) : DW'(q_data.den);
            fl_reg.par   <= q_data.den == '0;
            fl_reg.neg_x <= q_data.num_x[NW-1] ^ q_data.den[DW-1];
            fl_reg.neg_y <= q_data.num_y[NW-1] ^ q_data.den[DW-1];
            fl_reg.sat_x <= 1'b0;
            fl_reg.sat_y <= 1'b0;

            rx_reg[0]       <= ax_reg;
            ry_reg[0]       <= ay_reg;
            qx_reg[0]       <= '0;
            qy_reg[0]       <= '0;
            dd_reg[0]       <= ad_reg;
            fd_reg[0]       <= '{par:   fl_reg.par,
                                 sat_x: ax_reg >= {ad_reg, {CW{1'b0}}},
                                 sat_y: ay_reg >= {ad_reg, {CW{1'b0}}},
                                 neg_x: fl_reg.neg_x,
                                 neg_y: fl_reg.neg_y};
        end
    end

    for (genvar s = 0; s < CW; s++) begin : g_div
        localparam int B = CW - 1 - s;
        logic [NW-1:0] cand;
        logic          gx, gy;
        assign cand = NW'(dd_reg[s]) << B;
        assign gx   = rx_reg[s] >= cand;
        assign gy   = ry_reg[s] >= cand;
        always_ff @(posedge aclk) begin
            if (en) begin
                rx_reg[s+1]    <= gx ? rx_reg[s] - cand : rx_reg[s];
                ry_reg[s+1]    <= gy ? ry_reg[s] - cand : ry_reg[s];
                qx_reg[s+1]    <= qx_reg[s] | (CW'(gx) << B);
                qy_reg[s+1]    <= qy_reg[s] | (CW'(gy) << B);
                dd_reg[s+1]    <= dd_reg[s];
                fd_reg[s+1]    <= fd_reg[s];
            end
        end
    end

    function automatic logic [CW:0] clamp(input logic [CW-1:0] q, input logic neg,
                                          input logic pre);
        logic [CW-1:0] lim;
        logic [CW-1:0] mag;
        logic          sat;
        lim = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        sat = pre || (q > lim);
        mag = sat ? lim : q;
        return {sat, neg ? CW'(-mag) : mag};
    endfunction

    assign fe = fd_reg[CW];

    always_comb begin
        {sx_next, cx_next} = clamp(qx_reg[CW], fe.neg_x, fe.sat_x);
        {sy_next, cy_next} = clamp(qy_reg[CW], fe.neg_y, fe.sat_y);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            par_reg <= fe.par;
            cx_reg  <= fe.par ? '0 : cx_next;
            cy_reg  <= fe.par ? '0 : cy_next;
            ovf_reg <= !fe.par && (sx_next || sy_next);
        end
    end

`ifndef SYNTH
    a_par_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && par_reg |-> cx_reg == '0 && cy_reg == '0 && !ovf_reg)
        else $error("parallel result not cleared");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(cx_reg) && $stable(cy_reg))
        else $error("stalled result changed");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg)) else $error("pipeline moved while stalled");
`endif

endmodule
